@@ rtl/hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv_pkg
// Types, constants and helper functions shared by the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // Field widths of the pixel and color channels.
    localparam int HUE_W   = 16;
    localparam int CHAN_W  = 8;

    // A bias of 92 * 360 moves every signed hue into a positive range
    // without changing its residue modulo 360.
    localparam int BIASED_W   = 17;
    localparam int HUE_BIAS   = 33120;
    localparam int DEG_FULL   = 360;
    localparam int DEG_SECTOR = 60;
    localparam int HUE_MOD_W  = 9;
    localparam int ANGLE_W    = 6;
    localparam int TURNS_W    = 8;

    // Reciprocal of 360: floor(u / 360) == (u * HUE_RECIP) >> HUE_SHIFT, exact
    // for every biased hue below 2^17.
    localparam int HUE_RECIP_W = 18;
    localparam int HUE_RECIP   = 186414;
    localparam int HUE_SHIFT   = 26;

    // Reciprocal of 255, exact for every 16-bit dividend.
    localparam int CHAN_FULL     = 255;
    localparam int PROD_W        = 16;
    localparam int DIV255_RECIP_W = 16;
    localparam int DIV255_RECIP  = 32897;
    localparam int DIV255_SHIFT  = 23;

    // Reciprocal of 60, exact for every dividend below 2^14.
    localparam int RAMP_W        = 14;
    localparam int DIV60_RECIP_W = 15;
    localparam int DIV60_RECIP   = 17477;
    localparam int DIV60_SHIFT   = 20;

    // Hue sectors, named by the channel at full level and the one that moves.
    typedef enum logic [2:0] {
        SEC_RED_GREEN  = 3'd0,
        SEC_GREEN_RED  = 3'd1,
        SEC_GREEN_BLUE = 3'd2,
        SEC_BLUE_GREEN = 3'd3,
        SEC_BLUE_RED   = 3'd4,
        SEC_RED_BLUE   = 3'd5
    } sector_t;

    // Result of the front end: reduced hue, the low level and the value level.
    typedef struct packed {
        logic [HUE_MOD_W-1:0] hue;
        logic [CHAN_W-1:0]    low;
        logic [CHAN_W-1:0]    high;
    } front_t;

    // Result of the ramp section: sector and the three levels to mix.
    typedef struct packed {
        sector_t           sector;
        logic [CHAN_W-1:0] low;
        logic [CHAN_W-1:0] high;
        logic [CHAN_W-1:0] rise;
    } ramp_t;

    // Start angle of a sector in degrees.
    function automatic logic [HUE_MOD_W-1:0] sector_base(input sector_t sec);
        logic [HUE_MOD_W-1:0] base;
        unique case (sec)
            SEC_RED_GREEN:  base = HUE_MOD_W'(0);
            SEC_GREEN_RED:  base = HUE_MOD_W'(DEG_SECTOR);
            SEC_GREEN_BLUE: base = HUE_MOD_W'(2 * DEG_SECTOR);
            SEC_BLUE_GREEN: base = HUE_MOD_W'(3 * DEG_SECTOR);
            SEC_BLUE_RED:   base = HUE_MOD_W'(4 * DEG_SECTOR);
            default:        base = HUE_MOD_W'(5 * DEG_SECTOR);
        endcase
        return base;
    endfunction

endpackage

@@ rtl/hsv_pixel_if.sv @@
// ----------------------------------------------------------------------------
// hsv_pixel_if
// Request channel that carries one HSV pixel.
// ----------------------------------------------------------------------------
interface hsv_pixel_if;
    logic                            valid;
    logic                            ready;
    logic signed [hsv_pkg::HUE_W-1:0] hue_degrees;
    logic [hsv_pkg::CHAN_W-1:0]      saturation;
    logic [hsv_pkg::CHAN_W-1:0]      brightness;

    modport source (output valid, output hue_degrees, output saturation,
                    output brightness, input ready);
    modport sink   (input valid, input hue_degrees, input saturation,
                    input brightness, output ready);
endinterface

@@ rtl/hsv_rgb_if.sv @@
// ----------------------------------------------------------------------------
// hsv_rgb_if
// Request channel that carries one RGB color triple.
// ----------------------------------------------------------------------------
interface hsv_rgb_if;
    logic                       valid;
    logic                       ready;
    logic [hsv_pkg::CHAN_W-1:0] red;
    logic [hsv_pkg::CHAN_W-1:0] green;
    logic [hsv_pkg::CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

@@ rtl/hsv_front.sv @@
// ----------------------------------------------------------------------------
// hsv_front
// Stages one and two: hue reduction modulo 360 and the low level
// (255 - s) * v / 255, both by reciprocal multiplication.
// ----------------------------------------------------------------------------
module hsv_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [hsv_pkg::HUE_W-1:0] hue_degrees,
    input  logic [hsv_pkg::CHAN_W-1:0]       saturation,
    input  logic [hsv_pkg::CHAN_W-1:0]       brightness,
    output logic                             out_valid,
    input  logic                             out_ready,
    output hsv_pkg::front_t                  out_data
);

    localparam int BW   = hsv_pkg::BIASED_W;
    localparam int HPW  = BW + hsv_pkg::HUE_RECIP_W;
    localparam int LPW  = hsv_pkg::PROD_W + hsv_pkg::DIV255_RECIP_W;

    // Stage registers.
    logic                          s1_valid_reg;
    logic [BW-1:0]                 s1_biased_reg;
    logic [hsv_pkg::TURNS_W-1:0]   s1_turns_reg;
    logic [hsv_pkg::PROD_W-1:0]    s1_prod_reg;
    logic [hsv_pkg::CHAN_W-1:0]    s1_high_reg;
    logic                          s2_valid_reg;
    hsv_pkg::front_t               s2_data_reg;

    logic                          s1_ready;
    logic                          s2_ready;
    logic [BW:0]                   biased_wide;
    logic [HPW-1:0]                turns_prod;
    logic [BW-1:0]                 turns_deg;
    logic [BW-1:0]                 hue_rem;
    logic [LPW-1:0]                low_prod;
    hsv_pkg::front_t               s2_data_next;

    // Each stage takes a new request when empty or when it drains forward.
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage one: bias the hue, count whole turns, form (255 - s) * v.
    assign biased_wide = {{2{hue_degrees[hsv_pkg::HUE_W-1]}}, hue_degrees}
                         + (BW+1)'(hsv_pkg::HUE_BIAS);
    assign turns_prod  = HPW'(biased_wide[BW-1:0]) * HPW'(hsv_pkg::HUE_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_biased_reg <= biased_wide[BW-1:0];
            s1_turns_reg  <= turns_prod[hsv_pkg::HUE_SHIFT +: hsv_pkg::TURNS_W];
            s1_prod_reg   <= hsv_pkg::PROD_W'(hsv_pkg::CHAN_W'(hsv_pkg::CHAN_FULL)
                                              - saturation)
                             * hsv_pkg::PROD_W'(brightness);
            s1_high_reg   <= brightness;
        end
    end

    // Stage two: remove whole turns and divide the product by 255.
    assign turns_deg = BW'(s1_turns_reg) * BW'(hsv_pkg::DEG_FULL);
    assign hue_rem   = s1_biased_reg - turns_deg;
    assign low_prod  = LPW'(s1_prod_reg) * LPW'(hsv_pkg::DIV255_RECIP);

    always_comb
    begin
        s2_data_next.hue  = hue_rem[hsv_pkg::HUE_MOD_W-1:0];
        s2_data_next.low  = low_prod[hsv_pkg::DIV255_SHIFT +: hsv_pkg::CHAN_W];
        s2_data_next.high = s1_high_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // The reduced hue always lands inside one turn.
    a_hue_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_data_reg.hue < hsv_pkg::HUE_MOD_W'(hsv_pkg::DEG_FULL)))
        else $error("reduced hue outside 0..359");

    // The low level never exceeds the value level.
    a_low_le_high: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_data_reg.low <= s2_data_reg.high))
        else $error("low level above value level");

    // A stalled stage two holds its request.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |=> (s2_valid_reg && $stable(s2_data_reg)))
        else $error("stage two changed while stalled");

endmodule

@@ rtl/hsv_ramp.sv @@
// ----------------------------------------------------------------------------
// hsv_ramp
// Stages three to five: sector and mirrored ramp angle, the product
// (v - low) * angle, and its division by 60.
// ----------------------------------------------------------------------------
module hsv_ramp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hsv_pkg::front_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hsv_pkg::ramp_t  out_data
);

    localparam int CW  = hsv_pkg::CHAN_W;
    localparam int RW  = hsv_pkg::RAMP_W;
    localparam int QPW = RW + hsv_pkg::DIV60_RECIP_W;

    // Stage registers.
    logic                          s3_valid_reg;
    hsv_pkg::sector_t              s3_sector_reg;
    logic [hsv_pkg::ANGLE_W-1:0]   s3_angle_reg;
    logic [CW-1:0]                 s3_low_reg;
    logic [CW-1:0]                 s3_high_reg;
    logic                          s4_valid_reg;
    hsv_pkg::sector_t              s4_sector_reg;
    logic [RW-1:0]                 s4_ramp_reg;
    logic [CW-1:0]                 s4_low_reg;
    logic [CW-1:0]                 s4_high_reg;
    logic                          s5_valid_reg;
    hsv_pkg::ramp_t                s5_data_reg;

    logic                          s3_ready;
    logic                          s4_ready;
    logic                          s5_ready;
    hsv_pkg::sector_t              sector;
    logic [hsv_pkg::HUE_MOD_W-1:0] offset;
    logic [hsv_pkg::ANGLE_W-1:0]   angle;
    logic [CW-1:0]                 span;
    logic [QPW-1:0]                rise_prod;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    // Stage three: find the sector by comparing against its boundaries.
    always_comb
    begin
        priority if (in_data.hue >= hsv_pkg::HUE_MOD_W'(5 * hsv_pkg::DEG_SECTOR))
            sector = hsv_pkg::SEC_RED_BLUE;
        else if (in_data.hue >= hsv_pkg::HUE_MOD_W'(4 * hsv_pkg::DEG_SECTOR))
            sector = hsv_pkg::SEC_BLUE_RED;
        else if (in_data.hue >= hsv_pkg::HUE_MOD_W'(3 * hsv_pkg::DEG_SECTOR))
            sector = hsv_pkg::SEC_BLUE_GREEN;
        else if (in_data.hue >= hsv_pkg::HUE_MOD_W'(2 * hsv_pkg::DEG_SECTOR))
            sector = hsv_pkg::SEC_GREEN_BLUE;
        else if (in_data.hue >= hsv_pkg::HUE_MOD_W'(hsv_pkg::DEG_SECTOR))
            sector = hsv_pkg::SEC_GREEN_RED;
        else
            sector = hsv_pkg::SEC_RED_GREEN;
    end

    // Odd sectors ramp downward, so their angle is mirrored.
    assign offset = in_data.hue - hsv_pkg::sector_base(sector);
    assign angle  = sector[0]
                    ? hsv_pkg::ANGLE_W'(hsv_pkg::DEG_SECTOR) - offset[hsv_pkg::ANGLE_W-1:0]
                    : offset[hsv_pkg::ANGLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            s3_sector_reg <= sector;
            s3_angle_reg  <= angle;
            s3_low_reg    <= in_data.low;
            s3_high_reg   <= in_data.high;
        end
    end

    // Stage four: scale the span between high and low by the angle.
    assign span = s3_high_reg - s3_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_ramp_reg   <= RW'(span) * RW'(s3_angle_reg);
            s4_low_reg    <= s3_low_reg;
            s4_high_reg   <= s3_high_reg;
        end
    end

    // Stage five: divide the scaled span by 60.
    assign rise_prod = QPW'(s4_ramp_reg) * QPW'(hsv_pkg::DIV60_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (s5_ready)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && s4_valid_reg)
        begin
            s5_data_reg.sector <= s4_sector_reg;
            s5_data_reg.low    <= s4_low_reg;
            s5_data_reg.high   <= s4_high_reg;
            s5_data_reg.rise   <= rise_prod[hsv_pkg::DIV60_SHIFT +: CW];
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

    // The sector code and the ramp angle stay in their ranges.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_angle_reg <= hsv_pkg::ANGLE_W'(hsv_pkg::DEG_SECTOR)
                          && s3_sector_reg <= hsv_pkg::SEC_RED_BLUE))
        else $error("sector or ramp angle out of range");

    // The middle level never passes the value level.
    a_rise_fits: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (s5_data_reg.rise <= s5_data_reg.high - s5_data_reg.low))
        else $error("ramp rise exceeds span");

    // A stalled stage four keeps its product.
    a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !s5_ready) |=> (s4_valid_reg && $stable(s4_ramp_reg)))
        else $error("stage four changed while stalled");

endmodule

@@ rtl/hsv_mix.sv @@
// ----------------------------------------------------------------------------
// hsv_mix
// Stage six: form the middle level and route high, middle and low to the
// red, green and blue outputs by sector.
// ----------------------------------------------------------------------------
module hsv_mix (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  hsv_pkg::ramp_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hsv_pkg::CHAN_W-1:0] red,
    output logic [hsv_pkg::CHAN_W-1:0] green,
    output logic [hsv_pkg::CHAN_W-1:0] blue
);

    localparam int CW = hsv_pkg::CHAN_W;

    logic          s6_valid_reg;
    logic [CW-1:0] red_reg;
    logic [CW-1:0] green_reg;
    logic [CW-1:0] blue_reg;
    logic [CW-1:0] red_next;
    logic [CW-1:0] green_next;
    logic [CW-1:0] blue_next;
    logic [CW-1:0] middle;
    logic          s6_ready;

    assign s6_ready = !s6_valid_reg || out_ready;
    assign in_ready = s6_ready;

    // Black and gray pixels need no special path: with v == 0 all levels are
    // zero, and with s == 0 the low level already equals v.
    assign middle = in_data.low + in_data.rise;

    // Channel routing by sector.
    always_comb
    begin
        unique case (in_data.sector)
            hsv_pkg::SEC_RED_GREEN:
            begin
                red_next = in_data.high; green_next = middle; blue_next = in_data.low;
            end
            hsv_pkg::SEC_GREEN_RED:
            begin
                red_next = middle; green_next = in_data.high; blue_next = in_data.low;
            end
            hsv_pkg::SEC_GREEN_BLUE:
            begin
                red_next = in_data.low; green_next = in_data.high; blue_next = middle;
            end
            hsv_pkg::SEC_BLUE_GREEN:
            begin
                red_next = in_data.low; green_next = middle; blue_next = in_data.high;
            end
            hsv_pkg::SEC_BLUE_RED:
            begin
                red_next = middle; green_next = in_data.low; blue_next = in_data.high;
            end
            default:
            begin
                red_next = in_data.high; green_next = in_data.low; blue_next = middle;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (s6_ready)
        begin
            s6_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_ready && in_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // A request taken from the ramp section appears at the output next cycle.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && s6_ready) |=> s6_valid_reg)
        else $error("accepted request lost in output stage");

    // The output stage only fills from a valid request.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && s6_ready) |=> !s6_valid_reg)
        else $error("output stage filled without a request");

    // A held result keeps its channels.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s6_valid_reg && !out_ready) |=> ($stable(red_reg) && $stable(green_reg)
                                          && $stable(blue_reg)))
        else $error("output changed while stalled");

endmodule

@@ rtl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Integer HSV to RGB pixel converter, six register stages deep.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the "pixel" channel as a signed hue in degrees (any
//   16-bit value, reduced modulo 360), an 8-bit saturation and an 8-bit
//   brightness. Colors leave on the "rgb" channel as 8-bit red, green, blue.
//   Both channels use valid/ready; a request moves when both are high.
//   An accepted pixel passes through the stage registers of the front,
//   ramp and mix sections in order. Throughput is one pixel per cycle
//   while the receiver does not stall, set by the six stages each taking a
//   new pixel every clock; the widest paths are the reciprocal multipliers
//   for the divisions by 360, 255 and 60, each followed by a register.
//   Every stage has its own valid bit and takes a new request when it is
//   empty or passes its content on, so bubbles close up and the input stays
//   ready while the output holds a result, until all six stages are full.
//   When the receiver stalls, results hold in place; nothing is dropped or
//   repeated. Reset clears all valid bits; the pipeline is empty and ready
//   once reset is released. Pixels are independent of each other.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic               clk,
    input  logic               rst_n,
    hsv_pixel_if.sink          pixel,
    hsv_rgb_if.source          rgb
);

    logic            front_valid;
    logic            front_ready;
    hsv_pkg::front_t front_data;
    logic            ramp_valid;
    logic            ramp_ready;
    hsv_pkg::ramp_t  ramp_data;

    // Hue reduction and low level.
    hsv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pixel.valid),
        .in_ready    (pixel.ready),
        .hue_degrees (pixel.hue_degrees),
        .saturation  (pixel.saturation),
        .brightness  (pixel.brightness),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_data    (front_data)
    );

    // Sector, ramp angle and middle-level rise.
    hsv_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_data  (ramp_data)
    );

    // Channel routing and output register.
    hsv_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_data   (ramp_data),
        .out_valid (rgb.valid),
        .out_ready (rgb.ready),
        .red       (rgb.red),
        .green     (rgb.green),
        .blue      (rgb.blue)
    );

endmodule
